// ===== hdl/vcdr_pkg.sv =====
package vcdr_pkg;

  // Grid and arithmetic sizes
  localparam int GRID_WIDTH  = 16;
  localparam int GRID_HEIGHT = 16;
  localparam int MAX_REFINE  = 100;
  localparam int WEIGHT_BITS = 16;
  localparam int NPIX        = GRID_WIDTH * GRID_HEIGHT;
  localparam int WTAB_DEPTH  = 129;

  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int YW     = $clog2(GRID_HEIGHT);
  localparam int PW     = XW + YW;
  localparam int PCW    = PW + 1;
  localparam int WIDX_W = $clog2(WTAB_DEPTH);
  localparam int CW     = (XW > YW) ? XW : YW;
  localparam int D2W    = 2 * CW + 2;
  localparam int EW     = 25;
  localparam int ONES_W = $clog2(NPIX + 1);
  localparam int CNT_W  = $clog2(MAX_REFINE + 1);

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIT    = 2'd1,
    OP_RUN         = 2'd2,
    OP_READ_RANK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PAT_WR, S_READ, S_RESP, S_COPY, S_CLEAR,
    S_LE_SCAN, S_LE_CHK, S_SWEEP, S_PICK, S_INIT
  } state_e;

  typedef enum logic [3:0] {
    PH_COPY_INIT, PH_LOAD0, PH_REF_C, PH_REF_V, PH_SAVE, PH_P1,
    PH_RESTORE, PH_LOAD2, PH_P2, PH_INVERT, PH_LOAD3, PH_P3
  } phase_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  address;
    logic [15:0] weight_value;
    logic        pattern_bit;
  } item_t;

  typedef struct packed {
    logic [7:0] rank_value;
    logic [1:0] status;
    logic [8:0] ones_count;
    logic [6:0] refine_swaps;
  } result_t;

endpackage

// ===== hdl/void_and_cluster_dither_rank_core.sv =====
// Void-and-cluster blue-noise rank generator on a 16x16 toroidal grid.
// Input channel: item_i is taken at a clock edge where start is high and busy
// is low. Operations: load weight, load pattern bit, run generation, read rank.
// Result channel: done_o is high for exactly one cycle with result_o valid;
// the receiver cannot stall, so every result is taken in that cycle.
// Load weight, an address out of range and a run on a pattern with no ones or
// no zeros go from the accepting edge straight to the response state; load
// pattern bit first passes a write state and read rank a read state. busy drops
// the cycle after done_o. A run works in passes over all pixels: one per pixel
// search, per energy update and per pattern copy. Each refine iteration takes
// 4 passes and each rank 2 passes; every energy load takes a clear pass, a scan
// that reads and checks each pixel, and one pass per one-pixel.
// busy stays high for the whole item; one item is worked at a time.
// After reset a clearing pass zeroes the initial pattern and all ranks with
// busy high; the weight table holds nothing until written.
module void_and_cluster_dither_rank_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  vcdr_pkg::item_t  item_i,
  output logic             done_o,
  output vcdr_pkg::result_t result_o
);
  import vcdr_pkg::*;

  // Memories
  logic [WEIGHT_BITS-1:0] wt_mem   [WTAB_DEPTH];
  logic                   init_mem [NPIX];
  logic                   work_mem [NPIX];
  logic                   ref_mem  [NPIX];
  logic [EW-1:0]          en_mem   [NPIX];
  logic [7:0]             rank_mem [NPIX];

  // Sequencer registers
  state_e st_q, st_d;
  phase_e ph_q, ph_d;
  logic [PCW-1:0]    p_q, p_d, q_q, q_d, r_q, r_d;
  logic [PW-1:0]     c_q, c_d, best_q, best_d, pa_q;
  logic [EW-1:0]     best_e_q, best_e_d;
  logic              found_q, found_d, v1_q, far_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ONES_W-1:0] ones_q, ones_d;
  logic [6:0]        swaps_q, swaps_d;
  item_t             item_q;
  logic [7:0]        rank_res_q, rank_res_d;
  logic [1:0]        stat_q, stat_d;

  // Read data
  logic [WEIGHT_BITS-1:0] wt_rd_q;
  logic init_rd_q, work_rd_q, ref_rd_q;
  logic [EW-1:0] en_rd_q;
  logic [7:0]    rank_rd_q;

  // Memory controls
  logic              wt_we, init_we, work_we, ref_we, en_we, rank_we;
  logic [PW-1:0]     work_wa, work_ra, en_wa, rank_wa, init_ra, init_wa;
  logic              work_wd, copy_bit, init_wd;
  logic [EW-1:0]     en_wd, w_ext;
  logic [7:0]        rank_wd;
  logic [WIDX_W-1:0] wt_ra;

  logic accept, issue, p_end, clus, far_d;
  logic [XW-1:0]  px, qx, dx_raw, dx;
  logic [YW-1:0]  py, qy, dy_raw, dy;
  logic [D2W-1:0] d2;

  assign accept = start && !busy;
  assign issue  = (p_q < PCW'(NPIX));
  assign p_end  = (p_q == PCW'(NPIX)) && !v1_q;
  assign clus   = (ph_q == PH_REF_C) || (ph_q == PH_P1) || (ph_q == PH_P3);

  // Wrapped squared distance from the issued pixel to the target pixel
  always_comb begin
    px = p_q[XW-1:0];
    py = p_q[PW-1:XW];
    qx = q_q[XW-1:0];
    qy = q_q[PW-1:XW];
    dx_raw = (px > qx) ? px - qx : qx - px;
    dy_raw = (py > qy) ? py - qy : qy - py;
    dx = ({1'b0, dx_raw, 1'b0} > (XW+2)'(GRID_WIDTH)) ?
         XW'(GRID_WIDTH - int'(dx_raw)) : dx_raw;
    dy = ({1'b0, dy_raw, 1'b0} > (YW+2)'(GRID_HEIGHT)) ?
         YW'(GRID_HEIGHT - int'(dy_raw)) : dy_raw;
    d2 = D2W'(dx) * D2W'(dx) + D2W'(dy) * D2W'(dy);
    far_d = (d2 > D2W'(WTAB_DEPTH - 1));
    wt_ra = d2[WIDX_W-1:0];
  end

  // Next state and datapath registers
  always_comb begin
    st_d       = st_q;
    ph_d       = ph_q;
    p_d        = p_q;
    q_d        = q_q;
    r_d        = r_q;
    c_d        = c_q;
    best_d     = best_q;
    best_e_d   = best_e_q;
    found_d    = found_q;
    cnt_d      = cnt_q;
    ones_d     = ones_q;
    swaps_d    = swaps_q;
    rank_res_d = rank_res_q;
    stat_d     = stat_q;
    unique case (st_q)
      S_INIT: begin
        if (issue) begin
          p_d = p_q + 1'b1;
        end else begin
          p_d  = '0;
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          rank_res_d = '0;
          stat_d     = ST_OK;
          unique case (item_i.operation)
            OP_LOAD_WEIGHT: begin
              if (int'(item_i.address) >= WTAB_DEPTH) stat_d = ST_RANGE;
              st_d = S_RESP;
            end
            OP_LOAD_BIT: begin
              if (int'(item_i.address) >= NPIX) begin
                stat_d = ST_RANGE;
                st_d   = S_RESP;
              end else begin
                st_d = S_PAT_WR;
              end
            end
            OP_RUN: begin
              if (ones_q == '0 || ones_q == ONES_W'(NPIX)) begin
                stat_d  = ST_DEGEN;
                swaps_d = '0;
                st_d    = S_RESP;
              end else begin
                r_d   = PCW'(ones_q);
                cnt_d = '0;
                ph_d  = PH_COPY_INIT;
                st_d  = S_COPY;
                p_d   = '0;
              end
            end
            default: begin
              if (int'(item_i.address) >= NPIX) begin
                stat_d = ST_RANGE;
                st_d   = S_RESP;
              end else begin
                st_d = S_READ;
              end
            end
          endcase
        end
      end
      S_PAT_WR: begin
        ones_d = ones_q - ONES_W'(init_rd_q) + ONES_W'(item_q.pattern_bit);
        st_d   = S_RESP;
      end
      S_READ: begin
        rank_res_d = rank_rd_q;
        st_d       = S_RESP;
      end
      S_RESP: st_d = S_IDLE;
      S_COPY: begin
        if (issue) p_d = p_q + 1'b1;
        if (p_end) begin
          p_d = '0;
          priority case (ph_q)
            PH_SAVE: begin
              ph_d    = PH_P1;
              st_d    = S_PICK;
              found_d = 1'b0;
            end
            PH_RESTORE: begin
              ph_d = PH_LOAD2;
              st_d = S_CLEAR;
            end
            PH_INVERT: begin
              ph_d = PH_LOAD3;
              st_d = S_CLEAR;
            end
            default: begin
              ph_d = PH_LOAD0;
              st_d = S_CLEAR;
            end
          endcase
        end
      end
      S_CLEAR: begin
        if (issue) begin
          p_d = p_q + 1'b1;
        end else begin
          q_d  = '0;
          st_d = S_LE_SCAN;
        end
      end
      S_LE_SCAN: begin
        if (q_q == PCW'(NPIX)) begin
          p_d     = '0;
          found_d = 1'b0;
          priority case (ph_q)
            PH_LOAD0: begin
              ph_d = PH_REF_C;
              st_d = S_PICK;
            end
            PH_LOAD2: begin
              if (r_q < PCW'(NPIX / 2)) begin
                ph_d = PH_P2;
                st_d = S_PICK;
              end else begin
                ph_d = PH_INVERT;
                st_d = S_COPY;
              end
            end
            default: begin
              if (r_q < PCW'(NPIX)) begin
                ph_d = PH_P3;
                st_d = S_PICK;
              end else begin
                swaps_d = (int'(cnt_q) > 127) ? 7'd127 : 7'(cnt_q);
                st_d    = S_RESP;
              end
            end
          endcase
        end else begin
          st_d = S_LE_CHK;
        end
      end
      S_LE_CHK: begin
        if (work_rd_q) begin
          p_d  = '0;
          st_d = S_SWEEP;
        end else begin
          q_d  = q_q + 1'b1;
          st_d = S_LE_SCAN;
        end
      end
      S_PICK: begin
        if (issue) p_d = p_q + 1'b1;
        // keep the first pixel of the wanted color with the extreme energy
        if (v1_q && (work_rd_q == clus) &&
            (!found_q || (clus ? (en_rd_q > best_e_q) : (en_rd_q < best_e_q)))) begin
          best_d   = pa_q;
          best_e_d = en_rd_q;
          found_d  = 1'b1;
        end
        if (p_end) begin
          p_d  = '0;
          q_d  = {1'b0, best_q};
          st_d = S_SWEEP;
          if (ph_q == PH_REF_C) c_d = best_q;
        end
      end
      S_SWEEP: begin
        if (issue) p_d = p_q + 1'b1;
        if (p_end) begin
          p_d     = '0;
          found_d = 1'b0;
          priority case (ph_q)
            PH_REF_C: begin
              ph_d = PH_REF_V;
              st_d = S_PICK;
            end
            PH_REF_V: begin
              if (q_q[PW-1:0] == c_q || int'(cnt_q) + 1 >= MAX_REFINE) begin
                if (q_q[PW-1:0] != c_q) cnt_d = cnt_q + 1'b1;
                ph_d = PH_SAVE;
                st_d = S_COPY;
              end else begin
                cnt_d = cnt_q + 1'b1;
                ph_d  = PH_REF_C;
                st_d  = S_PICK;
              end
            end
            PH_P1: begin
              r_d = r_q - 1'b1;
              if (r_q != PCW'(1)) begin
                st_d = S_PICK;
              end else begin
                r_d  = PCW'(ones_q);
                ph_d = PH_RESTORE;
                st_d = S_COPY;
              end
            end
            PH_P2: begin
              r_d = r_q + 1'b1;
              if (r_q + 1'b1 < PCW'(NPIX / 2)) begin
                st_d = S_PICK;
              end else begin
                ph_d = PH_INVERT;
                st_d = S_COPY;
              end
            end
            PH_P3: begin
              r_d = r_q + 1'b1;
              if (r_q + 1'b1 < PCW'(NPIX)) begin
                st_d = S_PICK;
              end else begin
                swaps_d = (int'(cnt_q) > 127) ? 7'd127 : 7'(cnt_q);
                st_d    = S_RESP;
              end
            end
            default: begin
              q_d  = q_q + 1'b1;
              st_d = S_LE_SCAN;
            end
          endcase
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Memory controls and handshake outputs
  always_comb begin
    busy    = (st_q != S_IDLE);
    done_o  = (st_q == S_RESP);
    wt_we   = accept && (item_i.operation == OP_LOAD_WEIGHT) &&
              (int'(item_i.address) < WTAB_DEPTH);
    init_we = (st_q == S_PAT_WR) || ((st_q == S_INIT) && issue);
    init_wa = (st_q == S_INIT) ? p_q[PW-1:0] : item_q.address[PW-1:0];
    init_wd = (st_q == S_INIT) ? 1'b0 : item_q.pattern_bit;
    init_ra = (st_q == S_IDLE) ? item_i.address[PW-1:0] : p_q[PW-1:0];
    work_ra = (st_q == S_LE_SCAN) ? q_q[PW-1:0] : p_q[PW-1:0];

    unique case (ph_q)
      PH_SAVE:    copy_bit = work_rd_q;
      PH_RESTORE: copy_bit = ref_rd_q;
      PH_INVERT:  copy_bit = !work_rd_q;
      default:    copy_bit = init_rd_q;
    endcase

    work_we = 1'b0;
    work_wa = pa_q;
    work_wd = copy_bit;
    ref_we  = 1'b0;
    if (st_q == S_COPY && v1_q) begin
      if (ph_q == PH_SAVE) ref_we = 1'b1;
      else                 work_we = 1'b1;
    end
    if (st_q == S_PICK && p_end) begin
      work_we = 1'b1;
      work_wa = best_q;
      work_wd = !clus;
    end

    // Clear ranks after reset, else write the rank of the picked pixel
    rank_we = ((st_q == S_INIT) && issue) ||
              ((st_q == S_PICK) && p_end &&
               ((ph_q == PH_P1) || (ph_q == PH_P2) || (ph_q == PH_P3)));
    rank_wa = (st_q == S_INIT) ? p_q[PW-1:0] : best_q;
    if (st_q == S_INIT) rank_wd = '0;
    else rank_wd = (ph_q == PH_P1) ? 8'(r_q - 1'b1) : 8'(r_q);

    w_ext = far_q ? '0 : EW'(wt_rd_q);
    en_we = 1'b0;
    en_wa = pa_q;
    en_wd = clus ? en_rd_q - w_ext : en_rd_q + w_ext;
    if (st_q == S_CLEAR && issue) begin
      en_we = 1'b1;
      en_wa = p_q[PW-1:0];
      en_wd = '0;
    end else if (st_q == S_SWEEP && v1_q) begin
      en_we = 1'b1;
    end
  end

  // Memory arrays
  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[item_i.address[WIDX_W-1:0]] <= item_i.weight_value[WEIGHT_BITS-1:0];
    wt_rd_q <= wt_mem[wt_ra];
    if (init_we) init_mem[init_wa] <= init_wd;
    init_rd_q <= init_mem[init_ra];
    if (work_we) work_mem[work_wa] <= work_wd;
    work_rd_q <= work_mem[work_ra];
    if (ref_we) ref_mem[pa_q] <= copy_bit;
    ref_rd_q <= ref_mem[p_q[PW-1:0]];
    if (en_we) en_mem[en_wa] <= en_wd;
    en_rd_q <= en_mem[p_q[PW-1:0]];
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    rank_rd_q <= rank_mem[item_i.address[PW-1:0]];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
    pa_q       <= p_q[PW-1:0];
    far_q      <= far_d;
    q_q        <= q_d;
    r_q        <= r_d;
    c_q        <= c_d;
    best_q     <= best_d;
    best_e_q   <= best_e_d;
    cnt_q      <= cnt_d;
    rank_res_q <= rank_res_d;
    stat_q     <= stat_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_INIT;
      ph_q       <= PH_COPY_INIT;
      p_q        <= '0;
      found_q    <= 1'b0;
      v1_q       <= 1'b0;
      ones_q     <= '0;
      swaps_q    <= '0;
    end else begin
      st_q    <= st_d;
      ph_q    <= ph_d;
      p_q     <= p_d;
      found_q <= found_d;
      v1_q    <= issue && ((st_q == S_COPY) || (st_q == S_SWEEP) || (st_q == S_PICK));
      ones_q  <= ones_d;
      swaps_q <= swaps_d;
    end
  end

  assign result_o.rank_value   = rank_res_q;
  assign result_o.status       = stat_q;
  assign result_o.ones_count   = 9'(ones_q);
  assign result_o.refine_swaps = swaps_q;

endmodule

// ===== hdl/vcdr_checker.sv =====
module vcdr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input vcdr_pkg::result_t result_o
);
  import vcdr_pkg::*;

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // A result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held longer than one cycle");

  // A result only comes out while an item is in work
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done without busy");

  // Error results carry no rank
  a_err_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status != ST_OK) |-> (result_o.rank_value == 8'd0))
    else $error("rank on error result");

  // Status code stays within defined codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status != 2'd3)) else $error("undefined status");

endmodule

bind void_and_cluster_dither_rank_core vcdr_checker u_vcdr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== tb/sv/tb_void_and_cluster_dither_rank_core.sv =====
module tb_void_and_cluster_dither_rank_core;
  import vcdr_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  logic    done_o;
  result_t result_o;

  void_and_cluster_dither_rank_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [15:0]     weight_mem [WTAB_DEPTH];
  bit              seed_pat [NPIX];
  bit              cur_pat [NPIX];
  bit              refined_pat [NPIX];
  longint unsigned pix_energy [NPIX];
  logic [7:0]      rank_mem [NPIX];
  logic [6:0]      swap_count;

  result_t pending_results [$];
  int      error_count;
  int      result_count;
  int      run_count;
  int      read_count;
  longint  cycle_count;

  function automatic longint unsigned pair_weight(int a, int b);
    int dx, dy, d2;
    dx = (a % GRID_WIDTH) - (b % GRID_WIDTH);
    dy = (a / GRID_WIDTH) - (b / GRID_WIDTH);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (2 * dx > GRID_WIDTH) dx = GRID_WIDTH - dx;
    if (2 * dy > GRID_HEIGHT) dy = GRID_HEIGHT - dy;
    d2 = dx * dx + dy * dy;
    return (d2 < WTAB_DEPTH) ? longint'(weight_mem[d2]) : 0;
  endfunction

  // True when some wrapped pixel distance has this squared length
  function automatic bit distance_used(int d);
    for (int a = 0; a <= GRID_WIDTH / 2; a++)
      for (int b = 0; b <= GRID_HEIGHT / 2; b++)
        if (a * a + b * b == d) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void flip_pixel(int q, bit one);
    if (cur_pat[q] == one) return;
    cur_pat[q] = one;
    for (int p = 0; p < NPIX; p++) begin
      if (one) pix_energy[p] += pair_weight(p, q);
      else pix_energy[p] -= pair_weight(p, q);
    end
  endfunction

  function automatic void rebuild_energy();
    for (int p = 0; p < NPIX; p++) pix_energy[p] = 0;
    for (int q = 0; q < NPIX; q++)
      if (cur_pat[q])
        for (int p = 0; p < NPIX; p++) pix_energy[p] += pair_weight(p, q);
  endfunction

  // Tightest cluster among ones, or largest void among zeros; lowest index wins ties
  function automatic int find_extreme(bit cluster);
    int best;
    bit found;
    best = 0;
    found = 0;
    for (int p = 0; p < NPIX; p++) begin
      if (cur_pat[p] != cluster) continue;
      if (!found || (cluster ? pix_energy[p] > pix_energy[best]
                             : pix_energy[p] < pix_energy[best])) begin
        best = p;
        found = 1;
      end
    end
    return best;
  endfunction

  function automatic int count_seed_ones();
    int n;
    n = 0;
    for (int p = 0; p < NPIX; p++) n += seed_pat[p];
    return n;
  endfunction

  function automatic void rank_pixels(int ones);
    int steps, r, c, v;
    steps = 0;
    cur_pat = seed_pat;
    rebuild_energy();
    // Refine: swap tightest cluster with largest void
    while (steps < MAX_REFINE) begin
      c = find_extreme(1'b1);
      flip_pixel(c, 1'b0);
      v = find_extreme(1'b0);
      flip_pixel(v, 1'b1);
      if (c == v) break;
      steps++;
    end
    swap_count = (steps > 127) ? 7'd127 : 7'(steps);
    refined_pat = cur_pat;
    // Remove clusters from the refined pattern
    for (r = ones; r > 0; r--) begin
      c = find_extreme(1'b1);
      flip_pixel(c, 1'b0);
      rank_mem[c] = 8'(r - 1);
    end
    // Fill voids up to half
    cur_pat = refined_pat;
    rebuild_energy();
    r = ones;
    while (r < NPIX / 2) begin
      v = find_extreme(1'b0);
      flip_pixel(v, 1'b1);
      rank_mem[v] = 8'(r);
      r++;
    end
    // Invert and remove clusters for the remaining ranks
    for (int p = 0; p < NPIX; p++) cur_pat[p] = ~cur_pat[p];
    rebuild_energy();
    while (r < NPIX) begin
      c = find_extreme(1'b1);
      flip_pixel(c, 1'b0);
      rank_mem[c] = 8'(r);
      r++;
    end
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t res;
    int ones;
    res = '0;
    res.status = ST_OK;
    case (op_e'(it.operation))
      OP_LOAD_WEIGHT: begin
        if (it.address < WTAB_DEPTH) weight_mem[it.address] = it.weight_value;
        else res.status = ST_RANGE;
      end
      OP_LOAD_BIT: begin
        if (it.address < NPIX) seed_pat[it.address] = it.pattern_bit;
        else res.status = ST_RANGE;
      end
      OP_RUN: begin
        ones = count_seed_ones();
        if (ones == 0 || ones == NPIX) begin
          res.status = ST_DEGEN;
          swap_count = '0;
        end else begin
          rank_pixels(ones);
        end
      end
      default: begin
        if (it.address < NPIX) res.rank_value = rank_mem[it.address];
        else res.status = ST_RANGE;
      end
    endcase
    ones = count_seed_ones();
    res.ones_count = (ones > 511) ? 9'd511 : 9'(ones);
    res.refine_swaps = swap_count;
    return res;
  endfunction

  // Send one item after a random gap; start stays high for back-to-back items
  task automatic send_item(op_e op, int addr, logic [15:0] wval, bit pbit);
    item_t it;
    int gap;
    result_t predicted;
    it.operation = op;
    it.address = 8'(addr);
    it.weight_value = wval;
    it.pattern_bit = pbit;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predicted = predict_result(it);
    pending_results = {pending_results, predicted};
    if (op == OP_RUN) run_count++;
    if (op == OP_READ_RANK) read_count++;
  endtask

  task automatic check_reset_state();
    send_item(OP_READ_RANK, 0, 16'h0000, 1'b0);
    send_item(OP_READ_RANK, NPIX - 1, 16'hFFFF, 1'b1);
    // Empty pattern: run is degenerate
    send_item(OP_RUN, 0, 16'h0000, 1'b0);
  endtask

  task automatic check_bad_addresses();
    send_item(OP_LOAD_WEIGHT, WTAB_DEPTH, 16'hFFFF, 1'b1);
    send_item(OP_LOAD_WEIGHT, 255, 16'h1234, 1'b0);
  endtask

  // Load every weight that a wrapped distance on the grid can reach
  task automatic load_weight_table();
    send_item(OP_LOAD_WEIGHT, 0, 16'hFFFF, 1'b0);
    send_item(OP_LOAD_WEIGHT, 1, 16'h0000, 1'b1);
    for (int d = 2; d < WTAB_DEPTH; d++)
      if (distance_used(d))
        send_item(OP_LOAD_WEIGHT, d, 16'($urandom_range(0, 65535) >> (d / 16)), 1'b0);
  endtask

  task automatic check_sparse_run();
    for (int k = 0; k < 16; k++)
      send_item(OP_LOAD_BIT, $urandom_range(0, NPIX - 1), 16'h0000, 1'b1);
    send_item(OP_LOAD_BIT, 17, 16'h0000, 1'b1);
    send_item(OP_RUN, 0, 16'h0000, 1'b0);
    for (int k = 0; k < 8; k++)
      send_item(OP_READ_RANK, $urandom_range(0, NPIX - 1), 16'h0000, 1'b0);
  endtask

  task automatic random_items(int n);
    int runs_left, pick;
    runs_left = 1;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_item(OP_LOAD_BIT, $urandom_range(0, 255), 16'($urandom),
                  bit'($urandom_range(0, 1)));
      else if (pick < 70)
        send_item(OP_READ_RANK, $urandom_range(0, 255), 16'($urandom),
                  bit'($urandom_range(0, 1)));
      else if (pick < 93)
        send_item(OP_LOAD_WEIGHT, $urandom_range(0, 255), 16'($urandom),
                  bit'($urandom_range(0, 1)));
      else if (runs_left > 0) begin
        send_item(OP_RUN, $urandom_range(0, 255), 16'($urandom), 1'b0);
        runs_left--;
      end else
        send_item(OP_READ_RANK, $urandom_range(0, 255), 16'h0000, 1'b0);
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", result_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.rank_value !== want.rank_value) begin
          $error("rank_value expected %0d got %0d", want.rank_value, result_o.rank_value);
          error_count++;
        end
        if (result_o.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, result_o.status);
          error_count++;
        end
        if (result_o.ones_count !== want.ones_count) begin
          $error("ones_count expected %0d got %0d", want.ones_count, result_o.ones_count);
          error_count++;
        end
        if (result_o.refine_swaps !== want.refine_swaps) begin
          $error("refine_swaps expected %0d got %0d", want.refine_swaps,
                 result_o.refine_swaps);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    result_count = 0;
    run_count = 0;
    read_count = 0;
    cycle_count = 0;
    swap_count = '0;
    for (int p = 0; p < NPIX; p++) begin
      seed_pat[p] = 1'b0;
      cur_pat[p] = 1'b0;
      rank_mem[p] = '0;
    end
    for (int d = 0; d < WTAB_DEPTH; d++) weight_mem[d] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_reset_state();
    check_bad_addresses();
    load_weight_table();
    check_sparse_run();
    random_items(30);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) error_count++;

    $display("Checked %0d results: %0d generation runs, %0d rank reads.",
             result_count, run_count, read_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/vcdr_pkg.sv
hdl/void_and_cluster_dither_rank_core.sv
hdl/vcdr_checker.sv
tb/sv/tb_void_and_cluster_dither_rank_core.sv
